>>> hdl/plk_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plk_pkg
// Shared codes, control types and defaults for the positional list engine.
// ----------------------------------------------------------------------------
package plk_pkg;

	localparam int unsigned CapacityDefault = 64;
	localparam int unsigned WordWidth       = 32;
	localparam int unsigned PosWidth        = 7;
	localparam int unsigned LenWidth        = 7;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_GET    = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic ins;   // open a slot at the position, shift tail right
		logic del;   // close the slot at the position, shift tail left
		logic ld;    // capture the word at the position into the read lane
		logic sh;    // move the read lane one cell toward cell zero
	} cell_ctl_t;

endpackage : plk_pkg
`default_nettype wire

>>> hdl/positional_list_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of up to CAPACITY signed words kept in a row of cells.
// ----------------------------------------------------------------------------
// Sequence: a start beat enters S_EXEC, which edits the cells; get and delete at a
//   valid position p then make p-1 read lane hops in S_WALK; S_DONE strobes done.
// Busy is high from the start beat until the done cycle, so the next beat is taken
//   at the edge that ends the done cycle: each command finishes before the next.
// The read lane, one cell per cycle toward cell zero, sets the get/delete time.
// The receiver cannot stall; each result is valid for exactly one cycle.
// Reset: arst_n clears the control and the word count; the list is empty.
// ----------------------------------------------------------------------------
module positional_list_engine
	import plk_pkg::*;
#(
	parameter int unsigned CAPACITY = CapacityDefault
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        start,
	output logic                       busy,
	input  wire [1:0]                  kind,
	input  wire [PosWidth-1:0]         position,
	input  wire signed [WordWidth-1:0] new_value,
	output logic                       done,
	output logic [1:0]                 status,
	output logic signed [WordWidth-1:0] read_value,
	output logic [LenWidth-1:0]        length,
	output logic                       is_empty
);

	// count width, and a compare width that holds both count+1 and position
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned PW = ((CW > PosWidth) ? CW : PosWidth) + 1;
	localparam logic [PW-1:0] CapW = PW'(CAPACITY);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_WALK,
		S_DONE
	} state_t;

	state_t                state_q;
	logic [CW-1:0]         count_q;
	op_t                   op_q;
	status_t               st_q;
	logic [PosWidth-1:0]   pos_q;
	logic [WordWidth-1:0]  val_q;
	logic [PosWidth-1:0]   steps_q;
	logic                  done_q;
	status_t               status_q;
	logic [WordWidth-1:0]  read_q;
	logic [LenWidth-1:0]   length_q;
	logic                  empty_q;

	logic                  accept;
	op_t                   op_in;
	logic [PW-1:0]         pos_w;
	logic [PW-1:0]         cnt_w;
	status_t               st_in;
	logic                  ok_q;
	logic                  rd_op;
	cell_ctl_t             ctl;

	logic [WordWidth-1:0]  word_row [CAPACITY];
	logic [WordWidth-1:0]  rd_row   [CAPACITY];

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign op_in  = op_t'(kind);
	assign pos_w  = PW'(position);
	assign cnt_w  = PW'(count_q);

	// range check first, then full store
	always_comb begin
		st_in = ST_OK;
		unique case (op_in)
			OP_INSERT: begin
				if ((pos_w == '0) || (pos_w > cnt_w + PW'(1))) begin
					st_in = ST_RANGE;
				end else if (cnt_w >= CapW) begin
					st_in = ST_FULL;
				end
			end
			OP_DELETE, OP_GET: begin
				if ((pos_w == '0) || (pos_w > cnt_w)) begin
					st_in = ST_RANGE;
				end
			end
			OP_CLEAR: st_in = ST_OK;
			default:  st_in = ST_OK;
		endcase
	end

	assign ok_q  = (st_q == ST_OK);
	assign rd_op = (op_q == OP_DELETE) || (op_q == OP_GET);

	// cell command: one edit cycle in S_EXEC, lane hops in S_WALK
	always_comb begin
		ctl     = '0;
		ctl.ins = (state_q == S_EXEC) && ok_q && (op_q == OP_INSERT);
		ctl.del = (state_q == S_EXEC) && ok_q && (op_q == OP_DELETE);
		ctl.ld  = (state_q == S_EXEC) && ok_q && rd_op;
		ctl.sh  = (state_q == S_WALK);
	end

	// the row of cells; besides the broadcast command and word, each reads only its neighbors
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [WordWidth-1:0] left_w;
		logic [WordWidth-1:0] right_w;
		logic [WordWidth-1:0] right_r;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = word_row[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_w = '0;
			assign right_r = '0;
		end else begin : g_mid_r
			assign right_w = word_row[i+1];
			assign right_r = rd_row[i+1];
		end

		plk_cell #(
			.CAPACITY (CAPACITY),
			.IDX      (i)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.position   (pos_q),
			.new_value  (val_q),
			.left_word  (left_w),
			.right_word (right_w),
			.right_rd   (right_r),
			.word       (word_row[i]),
			.rd         (rd_row[i])
		);
	end

	// command registers: payload, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op_in;
			st_q  <= st_in;
			pos_q <= position;
			val_q <= new_value;
		end
	end

	// sequencer, word count and registered result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			steps_q  <= '0;
			done_q   <= 1'b0;
			status_q <= ST_OK;
			read_q   <= '0;
			length_q <= '0;
			empty_q  <= 1'b1;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
						steps_q <= position - PosWidth'(1);
					end
				end
				S_EXEC: begin
					if (ok_q) begin
						unique case (op_q)
							OP_INSERT: count_q <= count_q + CW'(1);
							OP_DELETE: count_q <= count_q - CW'(1);
							OP_CLEAR:  count_q <= '0;
							OP_GET:    count_q <= count_q;
							default:   count_q <= count_q;
						endcase
					end
					if (ok_q && rd_op && (steps_q != '0)) begin
						state_q <= S_WALK;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_WALK: begin
					steps_q <= steps_q - PosWidth'(1);
					if (steps_q == PosWidth'(1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					state_q  <= S_IDLE;
					done_q   <= 1'b1;
					status_q <= st_q;
					read_q   <= (ok_q && rd_op) ? rd_row[0] : '0;
					length_q <= LenWidth'(count_q);
					empty_q  <= (count_q == '0);
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign read_value = read_q;
	assign length     = length_q;
	assign is_empty   = empty_q;

endmodule : positional_list_engine
`default_nettype wire

>>> hdl/plk_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plk_cell
// One list slot: holds the word at list position IDX+1 and one stage of the
// read lane that carries a fetched word toward cell zero.
// ----------------------------------------------------------------------------
module plk_cell
	import plk_pkg::*;
#(
	parameter int unsigned CAPACITY = CapacityDefault,
	parameter int unsigned IDX      = 0
) (
	input  wire                  clk,
	input  wire cell_ctl_t       ctl,
	input  wire [PosWidth-1:0]   position,
	input  wire [WordWidth-1:0]  new_value,
	input  wire [WordWidth-1:0]  left_word,
	input  wire [WordWidth-1:0]  right_word,
	input  wire [WordWidth-1:0]  right_rd,
	output logic [WordWidth-1:0] word,
	output logic [WordWidth-1:0] rd
);

	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned PW = ((CW > PosWidth) ? CW : PosWidth) + 1;
	localparam logic [PW-1:0] MyPos = PW'(IDX + 1);

	logic [PW-1:0]  pos_w;
	logic           hit;
	logic           above;
	logic [WordWidth-1:0] word_q;
	logic [WordWidth-1:0] rd_q;

	assign pos_w = PW'(position);
	assign hit   = (MyPos == pos_w);
	assign above = (MyPos > pos_w);

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (hit) begin
				word_q <= new_value;
			end else if (above) begin
				word_q <= left_word;
			end
		end else if (ctl.del) begin
			if (hit || above) begin
				word_q <= right_word;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld) begin
			rd_q <= hit ? word_q : '0;
		end else if (ctl.sh) begin
			rd_q <= right_rd;
		end
	end

	assign word = word_q;
	assign rd   = rd_q;

endmodule : plk_cell
`default_nettype wire

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// positional_list_engine testbench
// Drives list commands (insert, delete, get, clear) through the start/busy
// handshake. A queue-based mirror of the list predicts each answer, and a
// monitor checks every done strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import plk_pkg::*;

	localparam int unsigned Cap         = CapacityDefault;
	localparam int unsigned StallLimit  = 2000; // worst item is a walk to the last position plus an idle gap
	localparam int unsigned MaxReported = 10;
	localparam int unsigned TailCycles  = 80;   // covers the longest get/delete walk

	typedef logic signed [WordWidth-1:0] word_t;

	// one predicted answer beat
	typedef struct {
		status_t              st;
		word_t                rd;
		logic [LenWidth-1:0]  len;
		logic                 empty;
	} list_answer_t;

	localparam word_t WordMin = {1'b1, {(WordWidth-1){1'b0}}};
	localparam word_t WordMax = {1'b0, {(WordWidth-1){1'b1}}};

	// DUT ports; every input starts at a known value
	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 start     = 1'b0;
	op_t                  kind      = OP_INSERT;
	logic [PosWidth-1:0]  position  = '0;
	word_t                new_value = '0;
	logic                 busy;
	logic                 done;
	logic [1:0]           status;
	word_t                read_value;
	logic [LenWidth-1:0]  length;
	logic                 is_empty;

	// mirror of the list contents, head first
	word_t        list_words[$];
	// answers predicted at the start beat, waiting for their done strobe
	list_answer_t list_answers[$];

	int unsigned mismatches  = 0;
	int unsigned quiet_cycles = 0;
	int unsigned idle_pct    = 0;
	int unsigned n_items     = 0;
	int unsigned n_results   = 0;
	int unsigned n_kind[4]   = '{default: 0};
	int unsigned n_range     = 0;
	int unsigned n_full      = 0;
	int unsigned peak_len    = 0;

	positional_list_engine #(
		.CAPACITY(Cap)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.position(position),
		.new_value(new_value),
		.done(done),
		.status(status),
		.read_value(read_value),
		.length(length),
		.is_empty(is_empty)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Predictor: applies one command to the mirror and returns its answer.
	// A bad position wins over a full store; clear always succeeds.
	// ------------------------------------------------------------------------
	function automatic list_answer_t apply_list_op(op_t op, logic [PosWidth-1:0] pos,
			word_t val);
		list_answer_t a;
		int p;
		p = int'(pos);
		a.st = ST_OK;
		a.rd = '0;
		case (op)
			OP_INSERT: begin
				if (p < 1 || p > list_words.size() + 1)
					a.st = ST_RANGE;
				else if (list_words.size() >= Cap)
					a.st = ST_FULL;
				else
					list_words.insert(p - 1, val);
			end
			OP_DELETE: begin
				if (p < 1 || p > list_words.size())
					a.st = ST_RANGE;
				else begin
					a.rd = list_words[p - 1];
					list_words.delete(p - 1);
				end
			end
			OP_GET: begin
				if (p < 1 || p > list_words.size())
					a.st = ST_RANGE;
				else
					a.rd = list_words[p - 1];
			end
			default: begin
				list_words.delete();
			end
		endcase
		a.len = LenWidth'(list_words.size());
		a.empty = (list_words.size() == 0);
		return a;
	endfunction

	function automatic word_t rand_word();
		case ($urandom_range(19))
			0: return WordMin;
			1: return WordMax;
			2: return '0;
			3: return '1;
			default: return word_t'($urandom);
		endcase
	endfunction

	// Mostly legal positions; the rest hit zero, one past the end, or anything.
	function automatic logic [PosWidth-1:0] pick_position(op_t op);
		int top;
		int unsigned r;
		top = (op == OP_INSERT) ? list_words.size() + 1 : list_words.size();
		r = $urandom_range(99);
		if (r < 80)
			return PosWidth'($urandom_range(1, (top < 1) ? 1 : top));
		else if (r < 88)
			return '0;
		else if (r < 95)
			return PosWidth'(top + 1);
		else
			return PosWidth'($urandom_range(127));
	endfunction

	// ------------------------------------------------------------------------
	// Send one command beat. start stays high after acceptance unless an idle
	// gap follows, so back-to-back beats never lower and raise start in one step.
	// ------------------------------------------------------------------------
	task automatic send_item(op_t op, logic [PosWidth-1:0] pos, word_t val);
		list_answer_t a;
		kind      <= op;
		position  <= pos;
		new_value <= val;
		start     <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		// beat accepted at this edge
		a = apply_list_op(op, pos, val);
		list_answers.push_back(a);
		n_items++;
		n_kind[op]++;
		if (a.st == ST_RANGE)
			n_range++;
		if (a.st == ST_FULL)
			n_full++;
		if (list_words.size() > peak_len)
			peak_len = list_words.size();
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic note_error(string msg);
		mismatches++;
		if (mismatches <= MaxReported)
			$display("%0t ns: %s", $realtime, msg);
	endtask

	// ------------------------------------------------------------------------
	// Result monitor: done is a one-cycle strobe, taken at the edge ending it.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		list_answer_t want;
		if (arst_n && done) begin
			n_results++;
			if (list_answers.size() == 0) begin
				note_error($sformatf("result with nothing outstanding: status %0d value %0d len %0d",
					status, read_value, length));
			end else begin
				want = list_answers.pop_front();
				if (status !== want.st)
					note_error($sformatf("status: expected %0d, got %0d", want.st, status));
				if (read_value !== want.rd)
					note_error($sformatf("read_value: expected %0d, got %0d", want.rd,
						read_value));
				if (length !== want.len)
					note_error($sformatf("length: expected %0d, got %0d", want.len, length));
				if (is_empty !== want.empty)
					note_error($sformatf("is_empty: expected %0b, got %0b", want.empty,
						is_empty));
			end
		end
	end

	// Watchdog: too long without a command beat or a result ends the run.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			quiet_cycles <= 0;
		else if (quiet_cycles >= StallLimit) begin
			$display("watchdog: no beat for %0d cycles, %0d answers outstanding",
				StallLimit, list_answers.size());
			$display("RESULT: ERROR");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// ------------------------------------------------------------------------
	// Directed tests
	// ------------------------------------------------------------------------

	// Everything on an empty list is a range error, except insert at 1.
	task automatic test_empty_list();
		send_item(OP_GET, 7'd1, '0);
		send_item(OP_DELETE, 7'd1, '0);
		send_item(OP_INSERT, 7'd0, 32'sd5);
		send_item(OP_INSERT, 7'd2, 32'sd5);
		send_item(OP_GET, 7'd0, '0);
	endtask

	// Extreme words at head, tail and middle, then reads and removals at each end.
	task automatic test_edge_values();
		send_item(OP_INSERT, 7'd1, WordMax);
		send_item(OP_INSERT, 7'd1, WordMin);   // new head
		send_item(OP_INSERT, 7'd3, '0);        // new tail
		send_item(OP_INSERT, 7'd2, '1);        // middle: min, -1, max, 0
		send_item(OP_GET, 7'd1, '0);
		send_item(OP_GET, 7'd4, '0);
		send_item(OP_DELETE, 7'd4, WordMax);   // new_value ignored
		send_item(OP_DELETE, 7'd1, '0);
		send_item(OP_DELETE, 7'd2, '0);
		send_item(OP_GET, 7'd1, '0);
	endtask

	// Positions just past the end and with the top bit set.
	task automatic test_bad_positions();
		send_item(OP_GET, PosWidth'(list_words.size() + 1), '0);
		send_item(OP_INSERT, PosWidth'(list_words.size() + 2), WordMin);
		send_item(OP_DELETE, 7'd127, '0);
		send_item(OP_INSERT, 7'd127, WordMax);
		send_item(OP_GET, 7'd64, '0);
	endtask

	// Clear on a populated list, then on an empty one.
	task automatic test_clear();
		send_item(OP_INSERT, 7'd1, 32'sd123);
		send_item(OP_CLEAR, 7'd127, WordMax);
		send_item(OP_GET, 7'd1, '0);
		send_item(OP_CLEAR, 7'd0, '0);
	endtask

	// Fill the store at random positions, hit it while full (full beats and
	// bad positions, which win over full), then drain with reads mixed in.
	task automatic test_full_store();
		op_t op;
		while (list_words.size() < Cap)
			send_item(OP_INSERT, pick_position(OP_INSERT), rand_word());
		repeat (6) begin
			send_item(OP_INSERT, PosWidth'($urandom_range(1, Cap + 1)), rand_word());
			send_item(OP_INSERT, ($urandom_range(1) != 0) ? PosWidth'(0) :
				PosWidth'($urandom_range(Cap + 2, 127)), rand_word());
		end
		send_item(OP_GET, PosWidth'(Cap), '0);
		while (list_words.size() > 0) begin
			op = ($urandom_range(99) < 30) ? OP_GET : OP_DELETE;
			send_item(op, PosWidth'($urandom_range(1, list_words.size())), rand_word());
		end
	endtask

	// Free mix of all commands; inserts slightly outweigh deletes so the
	// length wanders across the whole range.
	task automatic test_random_mix(int unsigned count);
		op_t op;
		int unsigned r;
		repeat (count) begin
			r = $urandom_range(99);
			if (r < 40)
				op = OP_INSERT;
			else if (r < 65)
				op = OP_DELETE;
			else if (r < 97)
				op = OP_GET;
			else
				op = OP_CLEAR;
			send_item(op, pick_position(op), rand_word());
		end
	endtask

	initial begin
		int unsigned phase_idle[3];
		// receiver cannot stall, so only the sender's idling varies by phase
		phase_idle = '{0, 60, 28};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_list();
		test_edge_values();
		test_bad_positions();
		test_clear();

		foreach (phase_idle[i]) begin
			idle_pct = phase_idle[i];
			test_full_store();
			test_random_mix(410);
		end

		start <= 1'b0;
		while (list_answers.size() != 0)
			@(posedge clk);
		repeat (TailCycles) @(posedge clk);

		$display("Covered %0d commands (%0d insert, %0d delete, %0d get, %0d clear), %0d results",
			n_items, n_kind[OP_INSERT], n_kind[OP_DELETE], n_kind[OP_GET], n_kind[OP_CLEAR],
			n_results);
		$display("Range errors %0d, full-store rejects %0d, peak length %0d, mismatches %0d",
			n_range, n_full, peak_len, mismatches);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule : testbench

>>> files.f
hdl/plk_pkg.sv
hdl/plk_cell.sv
hdl/positional_list_engine.sv
verif/testbench.sv
